[design/uscal_pkg.sv]
// ----------------------------------------------------------------------------
// uscal_pkg: shared constants for the Unix seconds to UTC calendar converter
// Reciprocal constants for the fixed divisors and the month offset table.
// ----------------------------------------------------------------------------
package uscal_pkg;

   // Field widths
   localparam int unsigned SecsW   = 32;
   localparam int unsigned DaysW   = 16;   // up to 49710 days
   localparam int unsigned SodW    = 17;   // second of day, below 86400
   localparam int unsigned DoeW    = 18;   // day of 400-year era, below 146097
   localparam int unsigned YoeW    = 9;    // year of era, below 400
   localparam int unsigned DoyW    = 9;    // day of March-based year, below 366
   localparam int unsigned YearW   = 12;
   localparam int unsigned MonthW  = 4;
   localparam int unsigned DayW    = 5;
   localparam int unsigned HourW   = 5;
   localparam int unsigned MinuteW = 6;
   localparam int unsigned SecondW = 6;
   localparam int unsigned MsecW   = 12;   // second of hour, below 3600

   // Calendar constants
   localparam logic [SodW-1:0] SecsPerDay     = 17'd86400;
   localparam logic [19:0]     EpochShift     = 20'd719468;
   localparam logic [19:0]     EraOneStart    = 20'd730485;  // five eras of days
   localparam logic [19:0]     EraZeroStart   = 20'd584388;  // four eras of days
   localparam logic [YearW-1:0] EraHiYear     = 12'd2000;
   localparam logic [YearW-1:0] EraLoYear     = 12'd1600;

   // Days divisor: secs >> 7 divided by 675 (86400 = 128 * 675)
   localparam int unsigned     DayShiftK = 35;
   localparam logic [25:0]     DayMagic  = 26'((64'd1 << 35) / 675 + 64'd1);

   // doe / 1460
   localparam int unsigned     D1460K    = 29;
   localparam logic [18:0]     D1460Mag  = 19'(((64'd1 << 29) + 64'd1459) / 1460);

   // n / 365
   localparam int unsigned     D365K     = 27;
   localparam logic [18:0]     D365Mag   = 19'(((64'd1 << 27) + 64'd364) / 365);

   // sod / 3600
   localparam int unsigned     D3600K    = 29;
   localparam logic [17:0]     D3600Mag  = 18'(((64'd1 << 29) + 64'd3599) / 3600);

   // msec / 60
   localparam int unsigned     D60K      = 18;
   localparam logic [12:0]     D60Mag    = 13'(((64'd1 << 18) + 64'd59) / 60);

   // (5 * doy + 2) / 153
   localparam int unsigned     D153K     = 19;
   localparam logic [11:0]     D153Mag   = 12'(((64'd1 << 19) + 64'd152) / 153);

   // First day of each March-based month within the year: (153 * mp + 2) / 5
   function automatic logic [DoyW-1:0] month_start(input logic [MonthW-1:0] mp);
      logic [DoyW-1:0] res;
      case (mp)
         4'd0:    res = 9'd0;
         4'd1:    res = 9'd31;
         4'd2:    res = 9'd61;
         4'd3:    res = 9'd92;
         4'd4:    res = 9'd122;
         4'd5:    res = 9'd153;
         4'd6:    res = 9'd184;
         4'd7:    res = 9'd214;
         4'd8:    res = 9'd245;
         4'd9:    res = 9'd275;
         4'd10:   res = 9'd306;
         4'd11:   res = 9'd337;
         default: res = 9'd0;
      endcase
      return res;
   endfunction

endpackage

[design/uscal_date.sv]
// ----------------------------------------------------------------------------
// uscal_date: day count to civil date
// Six-stage pipeline turning days since the epoch into year, month and day
// with the era / day-of-era method and a March-based internal year.
// ----------------------------------------------------------------------------
module uscal_date
   import uscal_pkg::*;
(
   input  logic               clock,
   input  logic [DaysW-1:0]   days,
   output logic [YearW-1:0]   year,
   output logic [MonthW-1:0]  month,
   output logic [DayW-1:0]    day
);

   // Stage 2: split into era and day of era
   logic [19:0]        z;
   logic               era_hi_in;
   logic [DoeW-1:0]    doe_in;
   logic [DoeW-1:0]    doe2_ff;
   logic               era2_ff;

   assign z         = 20'(days) + EpochShift;
   assign era_hi_in = (z >= EraOneStart);
   assign doe_in    = DoeW'(z - (era_hi_in ? EraOneStart : EraZeroStart));

   always_ff @(posedge clock) begin
      doe2_ff <= doe_in;
      era2_ff <= era_hi_in;
   end

   // Stage 3: remove leap days so that a plain divide by 365 gives the year
   logic [36:0]        p1460;
   logic [6:0]         q1460;
   logic [2:0]         q36524;
   logic               last_day;
   logic [DoeW-1:0]    n_in;
   logic [DoeW-1:0]    n3_ff;
   logic [DoeW-1:0]    doe3_ff;
   logic               era3_ff;

   assign p1460    = 37'(doe2_ff) * 37'(D1460Mag);
   assign q1460    = p1460[D1460K+6:D1460K];
   assign q36524   = 3'(doe2_ff >= 18'd36524) + 3'(doe2_ff >= 18'd73048)
                   + 3'(doe2_ff >= 18'd109572) + 3'(doe2_ff >= 18'd146096);
   assign last_day = (doe2_ff == 18'd146096);
   assign n_in     = doe2_ff - DoeW'(q1460) + DoeW'(q36524) - DoeW'(last_day);

   always_ff @(posedge clock) begin
      n3_ff   <= n_in;
      doe3_ff <= doe2_ff;
      era3_ff <= era2_ff;
   end

   // Stage 4: year of era
   logic [36:0]        p365;
   logic [YoeW-1:0]    yoe4_ff;
   logic [DoeW-1:0]    doe4_ff;
   logic               era4_ff;

   assign p365 = 37'(n3_ff) * 37'(D365Mag);

   always_ff @(posedge clock) begin
      yoe4_ff <= p365[D365K+YoeW-1:D365K];
      doe4_ff <= doe3_ff;
      era4_ff <= era3_ff;
   end

   // Stage 5: day of the March-based year
   logic [DoeW-1:0]    year_days;
   logic [1:0]         q100;
   logic [DoyW-1:0]    doy5_ff;
   logic [YoeW-1:0]    yoe5_ff;
   logic               era5_ff;

   assign q100      = 2'(yoe4_ff >= 9'd100) + 2'(yoe4_ff >= 9'd200)
                    + 2'(yoe4_ff >= 9'd300);
   assign year_days = 18'(yoe4_ff) * 18'd365 + 18'(yoe4_ff >> 2) - 18'(q100);

   always_ff @(posedge clock) begin
      doy5_ff <= DoyW'(doe4_ff - year_days);
      yoe5_ff <= yoe4_ff;
      era5_ff <= era4_ff;
   end

   // Stage 6: March-based month index
   logic [10:0]        mp_num;
   logic [22:0]        p153;
   logic [MonthW-1:0]  mp6_ff;
   logic [DoyW-1:0]    doy6_ff;
   logic [YoeW-1:0]    yoe6_ff;
   logic               era6_ff;

   assign mp_num = 11'(doy5_ff) * 11'd5 + 11'd2;
   assign p153   = 23'(mp_num) * 23'(D153Mag);

   always_ff @(posedge clock) begin
      mp6_ff  <= p153[D153K+MonthW-1:D153K];
      doy6_ff <= doy5_ff;
      yoe6_ff <= yoe5_ff;
      era6_ff <= era5_ff;
   end

   // Stage 7: calendar month, day and year, January and February roll forward
   logic [MonthW-1:0]  month_in;
   logic [DoyW-1:0]    dom;
   logic [YearW-1:0]   year_in;
   logic [YearW-1:0]   year_ff;
   logic [MonthW-1:0]  month_ff;
   logic [DayW-1:0]    day_ff;

   assign month_in = (mp6_ff < 4'd10) ? mp6_ff + 4'd3 : mp6_ff - 4'd9;
   assign dom      = doy6_ff - month_start(mp6_ff) + 9'd1;
   assign year_in  = 12'(yoe6_ff) + (era6_ff ? EraHiYear : EraLoYear)
                   + 12'(month_in <= 4'd2);

   always_ff @(posedge clock) begin
      year_ff  <= year_in;
      month_ff <= month_in;
      day_ff   <= dom[DayW-1:0];
   end

   assign year  = year_ff;
   assign month = month_ff;
   assign day   = day_ff;

endmodule

[design/unix_seconds_to_utc_calendar.sv]
// ----------------------------------------------------------------------------
// unix_seconds_to_utc_calendar: Unix seconds to UTC date and time
// The result strobe is raised together with the result fields, after the input
// register plus seven pipeline stages.
// Throughput: one beat per cycle; busy is never raised, the pipeline is fully
// overlapped and the receiver cannot stall it.
// Reset clears the valid chain only; no result is strobed until fresh input.
// ----------------------------------------------------------------------------
module unix_seconds_to_utc_calendar
   import uscal_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [SecsW-1:0]   req_unix_seconds,
   output logic               rsp_valid,
   output logic [YearW-1:0]   rsp_year,
   output logic [MonthW-1:0]  rsp_month,
   output logic [DayW-1:0]    rsp_day,
   output logic [HourW-1:0]   rsp_hour,
   output logic [MinuteW-1:0] rsp_minute,
   output logic [SecondW-1:0] rsp_second
);

   localparam int unsigned Stages = 8;

   // Track beats down the pipeline
   logic [Stages-1:0]  vld_ff;
   logic [Stages-1:0]  vld_in;

   assign busy   = 1'b0;
   assign vld_in = {vld_ff[Stages-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Stage 0: capture the timestamp
   logic [SecsW-1:0]   secs0_ff;

   always_ff @(posedge clock) begin
      secs0_ff <= req_unix_seconds;
   end

   // Stage 1: whole days
   logic [50:0]        pday;
   logic [DaysW-1:0]   days1_ff;
   logic [SecsW-1:0]   secs1_ff;

   assign pday = 51'(secs0_ff[SecsW-1:7]) * 51'(DayMagic);

   always_ff @(posedge clock) begin
      days1_ff <= pday[DayShiftK+DaysW-1:DayShiftK];
      secs1_ff <= secs0_ff;
   end

   // Stage 2: second of day
   logic [32:0]        day_secs;
   logic [SodW-1:0]    sod2_ff;

   assign day_secs = 33'(days1_ff) * 33'(SecsPerDay);

   always_ff @(posedge clock) begin
      sod2_ff <= SodW'(secs1_ff - day_secs[SecsW-1:0]);
   end

   // Stage 3: hour
   logic [34:0]        phour;
   logic [HourW-1:0]   hour3_ff;
   logic [SodW-1:0]    sod3_ff;

   assign phour = 35'(sod2_ff) * 35'(D3600Mag);

   always_ff @(posedge clock) begin
      hour3_ff <= phour[D3600K+HourW-1:D3600K];
      sod3_ff  <= sod2_ff;
   end

   // Stage 4: second of hour
   logic [SodW-1:0]    hour_secs;
   logic [MsecW-1:0]   msec4_ff;
   logic [HourW-1:0]   hour4_ff;

   assign hour_secs = SodW'(hour3_ff) * 17'd3600;

   always_ff @(posedge clock) begin
      msec4_ff <= MsecW'(sod3_ff - hour_secs);
      hour4_ff <= hour3_ff;
   end

   // Stage 5: minute
   logic [24:0]        pmin;
   logic [MinuteW-1:0] minute5_ff;
   logic [MsecW-1:0]   msec5_ff;
   logic [HourW-1:0]   hour5_ff;

   assign pmin = 25'(msec4_ff) * 25'(D60Mag);

   always_ff @(posedge clock) begin
      minute5_ff <= pmin[D60K+MinuteW-1:D60K];
      msec5_ff   <= msec4_ff;
      hour5_ff   <= hour4_ff;
   end

   // Stage 6: second
   logic [MsecW-1:0]   min_secs;
   logic [SecondW-1:0] second6_ff;
   logic [MinuteW-1:0] minute6_ff;
   logic [HourW-1:0]   hour6_ff;

   assign min_secs = MsecW'(minute5_ff) * 12'd60;

   always_ff @(posedge clock) begin
      second6_ff <= SecondW'(msec5_ff - min_secs);
      minute6_ff <= minute5_ff;
      hour6_ff   <= hour5_ff;
   end

   // Stage 7: result register for time of day
   logic [HourW-1:0]   hour7_ff;
   logic [MinuteW-1:0] minute7_ff;
   logic [SecondW-1:0] second7_ff;

   always_ff @(posedge clock) begin
      hour7_ff   <= hour6_ff;
      minute7_ff <= minute6_ff;
      second7_ff <= second6_ff;
   end

   // Date path, stages 2 through 7
   uscal_date u_date (
      .clock (clock),
      .days  (days1_ff),
      .year  (rsp_year),
      .month (rsp_month),
      .day   (rsp_day)
   );

   assign rsp_valid  = vld_ff[Stages-1];
   assign rsp_hour   = hour7_ff;
   assign rsp_minute = minute7_ff;
   assign rsp_second = second7_ff;

endmodule

[tb/uscal_calendar_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uscal_calendar_checker: result checker for the Unix seconds converter
// Watches the request and result channels, predicts the UTC calendar fields
// of every accepted timestamp, and compares each result beat in order.
// ----------------------------------------------------------------------------
module uscal_calendar_checker
   import uscal_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [SecsW-1:0]   req_unix_seconds,
   input  logic               rsp_valid,
   input  logic [YearW-1:0]   rsp_year,
   input  logic [MonthW-1:0]  rsp_month,
   input  logic [DayW-1:0]    rsp_day,
   input  logic [HourW-1:0]   rsp_hour,
   input  logic [MinuteW-1:0] rsp_minute,
   input  logic [SecondW-1:0] rsp_second,
   output int                 mismatch_count,
   output int                 pending_count
);

   localparam logic [31:0] SecondsPerDay  = 32'd86400;
   localparam logic [31:0] DaysFromMar0   = 32'd719468;  // 0000-03-01 to epoch
   localparam logic [31:0] DaysIn400Years = 32'd146097;
   localparam int          ReportLimit    = 10;

   typedef struct packed {
      logic [YearW-1:0]   year;
      logic [MonthW-1:0]  month;
      logic [DayW-1:0]    day;
      logic [HourW-1:0]   hour;
      logic [MinuteW-1:0] minute;
      logic [SecondW-1:0] second;
   } utc_fields_type;

   utc_fields_type calendar_q[$];
   int             misses = 0;
   int             waiting = 0;

   assign mismatch_count = misses;
   assign pending_count  = waiting;

   // Split into day and second of day, then walk the March-based civil year
   function automatic utc_fields_type utc_from_unix(input logic [31:0] secs);
      logic [31:0] days, sod, z, era, doe, yoe, yr, doy, mp, mm;
      utc_fields_type f;
      days = secs / SecondsPerDay;
      sod  = secs % SecondsPerDay;
      z    = days + DaysFromMar0;
      era  = z / DaysIn400Years;
      doe  = z - era * DaysIn400Years;
      yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      yr   = yoe + era * 400;
      doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp   = (5 * doy + 2) / 153;
      mm   = (mp < 10) ? mp + 3 : mp - 9;
      // January and February belong to the following civil year
      if (mm <= 2)
         yr = yr + 1;
      f.year   = yr[YearW-1:0];
      f.month  = mm[MonthW-1:0];
      f.day    = DayW'(doy - (153 * mp + 2) / 5 + 1);
      f.hour   = HourW'(sod / 3600);
      f.minute = MinuteW'((sod / 60) % 60);
      f.second = SecondW'(sod % 60);
      return f;
   endfunction

   // Compare result beats, then queue the prediction for a new request beat
   always @(posedge clock) begin
      utc_fields_type want;
      utc_fields_type got;
      logic           bad;
      if (!reset) begin
         if (rsp_valid) begin
            got = '{rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute, rsp_second};
            if (calendar_q.size() == 0) begin
               misses = misses + 1;
               if (misses <= ReportLimit)
                  $display("%0t: result beat with nothing pending: %0d-%0d-%0d %0d:%0d:%0d",
                           $realtime, got.year, got.month, got.day,
                           got.hour, got.minute, got.second);
            end else begin
               want = calendar_q.pop_front();
               bad  = (got.year !== want.year) || (got.month !== want.month) ||
                      (got.day !== want.day) || (got.hour !== want.hour) ||
                      (got.minute !== want.minute) || (got.second !== want.second);
               if (bad) begin
                  misses = misses + 1;
                  if (misses <= ReportLimit) begin
                     $display("%0t: calendar mismatch", $realtime);
                     $display("   want %0d-%0d-%0d %0d:%0d:%0d",
                              want.year, want.month, want.day,
                              want.hour, want.minute, want.second);
                     $display("   got  %0d-%0d-%0d %0d:%0d:%0d",
                              got.year, got.month, got.day,
                              got.hour, got.minute, got.second);
                  end
               end
            end
         end
         if (start && !busy)
            calendar_q.push_back(utc_from_unix(req_unix_seconds));
      end
      waiting = calendar_q.size();
   end

endmodule

[tb/tb_unix_seconds_to_utc_calendar.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unix_seconds_to_utc_calendar: testbench for the Unix seconds converter
// Drives corner timestamps and random ones under several sender idle rates;
// the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_unix_seconds_to_utc_calendar
   import uscal_pkg::*;
;

   localparam int QuietLimit  = 2000;
   localparam int DrainCycles = 16;
   localparam int PerPhase    = 100;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [SecsW-1:0]   req_unix_seconds = '0;
   logic               busy;
   logic               rsp_valid;
   logic [YearW-1:0]   rsp_year;
   logic [MonthW-1:0]  rsp_month;
   logic [DayW-1:0]    rsp_day;
   logic [HourW-1:0]   rsp_hour;
   logic [MinuteW-1:0] rsp_minute;
   logic [SecondW-1:0] rsp_second;
   logic               beat_taken = 1'b0;
   int                 quiet_cycles = 0;
   int                 mismatches;
   int                 in_flight;

   // Epoch, day and hour edges, leap days, century years and the top of range
   logic [31:0] corner_times[$] = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd68169600, 32'd946684799, 32'd946684800, 32'd951782400, 32'd951868799,
      32'd4102444800, 32'd4107542399, 32'd4107542400, 32'h7FFF_FFFF,
      32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'hFFFF_FFFF
   };

   unix_seconds_to_utc_calendar uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_unix_seconds (req_unix_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day          (rsp_day),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second)
   );

   uscal_calendar_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_unix_seconds (req_unix_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day          (rsp_day),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .mismatch_count   (mismatches),
      .pending_count    (in_flight)
   );

   always #5 clock = ~clock;

   // Flag each accepted request beat for the driver
   always @(posedge clock) begin
      beat_taken <= !reset && start && !busy;
   end

   // End the run if neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("[unix_seconds_to_utc_calendar] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Pick a timestamp: full range, day edges, near the epoch or near the top
   function automatic logic [31:0] random_timestamp();
      logic [31:0] day_edges[7];
      logic [31:0] stamp;
      day_edges = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399};
      case ($urandom_range(0, 3))
         0: begin
            stamp = $urandom();
         end
         1: begin
            stamp = $urandom_range(0, 49709) * 32'd86400 + day_edges[$urandom_range(0, 6)];
         end
         2: begin
            stamp = $urandom_range(0, 32'h000F_FFFF);
         end
         default: begin
            stamp = 32'hFFFF_FFFF - $urandom_range(0, 32'h000F_FFFF);
         end
      endcase
      return stamp;
   endfunction

   // Send one beat after a random number of idle cycles; hold until accepted
   task automatic send_timestamp(input logic [31:0] secs, input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start            <= 1'b0;
         req_unix_seconds <= $urandom();
         @(negedge clock);
      end
      start            <= 1'b1;
      req_unix_seconds <= secs;
      @(negedge clock);
      while (!beat_taken)
         @(negedge clock);
   endtask

   initial begin
      int idle_pct[4];
      idle_pct = '{0, 55, 19, 0};
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (corner_times[i])
         send_timestamp(corner_times[i], 0);
      for (int p = 0; p < 4; p++) begin
         repeat (PerPhase)
            send_timestamp(random_timestamp(), idle_pct[p]);
      end
      start <= 1'b0;

      // Drain the pipeline, then allow a few cycles for stray beats
      @(negedge clock);
      while (in_flight != 0)
         @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      if (mismatches == 0 && in_flight == 0) begin
         $display("[unix_seconds_to_utc_calendar] OK");
      end else begin
         $display("[unix_seconds_to_utc_calendar] ERROR");
      end
      $finish;
   end

endmodule
